FILE: hdl/assert_macros.svh
// Assertion helpers shared by the block's modules.
// They use the clock i_clk and the synchronous active-low reset i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/imu_acc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IMU accumulator package
// Shared types, constants and helper functions of the sample accumulator.
// ---------------------------------------------------------------------------
package imu_acc_pkg;

    localparam int MAX_BATCH_DEF = 8;
    localparam int CNT_W         = 7;
    localparam int SUM_W         = 20;
    localparam int WORD_W        = 16;
    localparam int AXIS_W        = 44;
    localparam int GAIN_W        = 24;
    localparam int DS_W          = 4;
    localparam int TOL_W         = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int Q_DEPTH       = 4;
    localparam int Q_AW          = $clog2(Q_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_FAST_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_DS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_DS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TOL    = 3'd5;

    localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST = 24'd160673;
    localparam logic [GAIN_W-1:0] GYRO_GAIN_RST  = 24'd17855;
    localparam logic [TOL_W-1:0]  TEMP_TOL_RST   = 16'd400;

    typedef enum logic [1:0] {
        K_ACCEL = 2'd0,
        K_GYRO  = 2'd1,
        K_TEMP  = 2'd2,
        K_ERROR = 2'd3
    } t_kind;

    typedef struct packed {
        logic              fast_mode;
        logic [DS_W-1:0]   accel_ds;
        logic [DS_W-1:0]   gyro_ds;
        logic [GAIN_W-1:0] accel_gain;
        logic [GAIN_W-1:0] gyro_gain;
        logic [TOL_W-1:0]  temp_tol;
    } t_cfg;

    typedef struct packed {
        t_kind                    kind;
        logic signed [SUM_W-1:0]  x;
        logic signed [SUM_W-1:0]  y;
        logic signed [SUM_W-1:0]  z;
        logic                     div;
        logic [CNT_W-1:0]         cnt;
        logic                     last;
    } t_job;

    function automatic logic [SUM_W-1:0] sext_word(input logic [WORD_W-1:0] w);
        return {{(SUM_W-WORD_W){w[WORD_W-1]}}, w};
    endfunction

    function automatic logic temp_ok(input logic [WORD_W-1:0] t,
                                     input logic [WORD_W-1:0] c,
                                     input logic [TOL_W-1:0] tol);
        logic [WORD_W:0] d;
        logic [WORD_W:0] mag;
        d   = {t[WORD_W-1], t} - {c[WORD_W-1], c};
        mag = d[WORD_W] ? (~d + 1'b1) : d;
        return mag < {1'b0, tol};
    endfunction

    // True when the count is a multiple of the clamped downsample factor.
    function automatic logic is_due(input logic [4:0] c, input logic [DS_W-1:0] d);
        logic [DS_W-1:0] dd;
        logic            hit;
        dd  = (d == '0) ? 4'd1 : ((d > 4'd8) ? 4'd8 : d);
        hit = 1'b0;
        for (int k = 0; k < 32; k++) begin
            if ({3'b000, c} == 8'(k * int'(dd))) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

FILE: hdl/imu_acc_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IMU accumulator input channel
// Valid/ready channel that carries one FIFO record per item.
// ---------------------------------------------------------------------------
interface imu_acc_in_if;
    logic                     valid;
    logic                     ready;
    logic signed [15:0]       raw_word0;
    logic signed [15:0]       raw_word1;
    logic signed [15:0]       raw_word2;
    logic signed [15:0]       raw_word3;
    logic signed [15:0]       raw_word4;
    logic signed [15:0]       raw_word5;
    logic signed [15:0]       raw_temp_word;
    logic signed [15:0]       live_temp;
    logic                     live_temp_valid;
    logic                     last_in_batch;

    modport source (output valid, raw_word0, raw_word1, raw_word2, raw_word3,
                    raw_word4, raw_word5, raw_temp_word, live_temp,
                    live_temp_valid, last_in_batch, input ready);
    modport sink (input valid, raw_word0, raw_word1, raw_word2, raw_word3,
                  raw_word4, raw_word5, raw_temp_word, live_temp,
                  live_temp_valid, last_in_batch, output ready);
endinterface

FILE: hdl/imu_acc_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IMU accumulator result channel
// Valid/ready channel that carries one result item.
// ---------------------------------------------------------------------------
interface imu_acc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [43:0] axis_x;
    logic signed [43:0] axis_y;
    logic signed [43:0] axis_z;
    logic               last;

    modport source (output valid, kind, axis_x, axis_y, axis_z, last, input ready);
    modport sink (input valid, kind, axis_x, axis_y, axis_z, last, output ready);
endinterface

FILE: hdl/imu_acc_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IMU accumulator front end
// Checks temperature, keeps the sums and counts, and queues result jobs.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module imu_acc_front #(
    parameter int MAX_BATCH = imu_acc_pkg::MAX_BATCH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    imu_acc_in_if.sink          i_item,
    input  imu_acc_pkg::t_cfg   i_cfg,
    output imu_acc_pkg::t_job   o_job,
    output logic                o_push,
    input  logic                i_full
);
    localparam int BW = $clog2(MAX_BATCH + 1);
    localparam int SW = imu_acc_pkg::SUM_W;
    localparam int WW = imu_acc_pkg::WORD_W;

    logic                    r_skip, n_skip;
    logic [BW-1:0]           r_bcnt, n_bcnt;
    logic signed [SW-1:0]    r_bsum, n_bsum;
    logic [WW-1:0]           r_cache, n_cache;
    logic signed [SW-1:0]    r_as [3];
    logic signed [SW-1:0]    n_as [3];
    logic signed [SW-1:0]    r_gs [3];
    logic signed [SW-1:0]    n_gs [3];
    logic [3:0]              r_acnt, n_acnt;
    logic [4:0]              r_gcnt, n_gcnt;
    imu_acc_pkg::t_job       r_jobs [3];
    imu_acc_pkg::t_job       n_jobs [3];
    logic [1:0]              r_nj, n_nj;
    logic [1:0]              r_jidx;
    logic                    pend;
    logic                    accept;

    assign pend         = (r_jidx != r_nj);
    assign i_item.ready = !pend;
    assign accept       = i_item.valid && i_item.ready;
    assign o_push       = pend && !i_full;
    assign o_job        = r_jobs[r_jidx];

    always_comb begin
        logic [BW:0]          inc;
        logic                 last;
        logic                 ok1, ok2;
        logic [WW-1:0]        chk;
        logic [WW-1:0]        t;
        logic signed [SW-1:0] sum_t;
        imu_acc_pkg::t_job    nj0;
        logic [1:0]           nj;

        n_skip  = r_skip;
        n_bcnt  = r_bcnt;
        n_bsum  = r_bsum;
        n_cache = r_cache;
        n_as    = r_as;
        n_gs    = r_gs;
        n_acnt  = r_acnt;
        n_gcnt  = r_gcnt;
        n_jobs  = r_jobs;
        n_nj    = r_nj;
        nj0     = '0;
        nj      = 2'd0;
        t       = i_item.raw_temp_word;
        inc     = {1'b0, r_bcnt} + 1'b1;
        last    = i_item.last_in_batch || (inc >= (BW+1)'(MAX_BATCH));
        ok1     = imu_acc_pkg::temp_ok(t, r_cache, i_cfg.temp_tol);
        chk     = (!ok1 && i_item.live_temp_valid) ? i_item.live_temp : r_cache;
        ok2     = imu_acc_pkg::temp_ok(t, chk, i_cfg.temp_tol);
        sum_t   = r_bsum + imu_acc_pkg::sext_word(t);

        if (accept) begin
            if (r_skip) begin
                if (last) begin
                    n_skip = 1'b0;
                    n_bcnt = '0;
                    n_bsum = '0;
                end else begin
                    n_bcnt = inc[BW-1:0];
                end
            end else if (!ok2) begin
                n_cache          = chk;
                nj0.kind         = imu_acc_pkg::K_ERROR;
                n_jobs[0]        = nj0;
                nj               = 2'd1;
                n_bsum           = '0;
                n_skip           = !last;
                n_bcnt           = last ? '0 : BW'(1);
            end else begin
                n_cache = chk;
                n_bsum  = last ? '0 : sum_t;
                n_bcnt  = last ? '0 : inc[BW-1:0];
                if (i_cfg.fast_mode) begin
                    if (!r_gcnt[0]) begin
                        n_as[0] = r_as[0] + imu_acc_pkg::sext_word(i_item.raw_word1);
                        n_as[1] = r_as[1] + imu_acc_pkg::sext_word(i_item.raw_word0);
                        n_as[2] = r_as[2] - imu_acc_pkg::sext_word(i_item.raw_word2);
                        n_acnt  = r_acnt + 1'b1;
                        if (imu_acc_pkg::is_due({1'b0, n_acnt}, i_cfg.accel_ds)) begin
                            nj0.kind   = imu_acc_pkg::K_ACCEL;
                            nj0.x      = n_as[0];
                            nj0.y      = n_as[1];
                            nj0.z      = n_as[2];
                            n_jobs[nj] = nj0;
                            nj         = nj + 1'b1;
                            n_as[0]    = '0;
                            n_as[1]    = '0;
                            n_as[2]    = '0;
                            n_acnt     = '0;
                            n_gcnt     = '0;
                        end
                    end
                    n_gcnt  = n_gcnt + 1'b1;
                    n_gs[0] = r_gs[0] + imu_acc_pkg::sext_word(i_item.raw_word4);
                    n_gs[1] = r_gs[1] + imu_acc_pkg::sext_word(i_item.raw_word3);
                    n_gs[2] = r_gs[2] - imu_acc_pkg::sext_word(i_item.raw_word5);
                    if (imu_acc_pkg::is_due(n_gcnt, i_cfg.gyro_ds)) begin
                        nj0        = '0;
                        nj0.kind   = imu_acc_pkg::K_GYRO;
                        nj0.x      = n_gs[0];
                        nj0.y      = n_gs[1];
                        nj0.z      = n_gs[2];
                        n_jobs[nj] = nj0;
                        nj         = nj + 1'b1;
                        n_gs[0]    = '0;
                        n_gs[1]    = '0;
                        n_gs[2]    = '0;
                    end
                    if (last) begin
                        nj0        = '0;
                        nj0.kind   = imu_acc_pkg::K_TEMP;
                        nj0.x      = sum_t;
                        nj0.div    = 1'b1;
                        nj0.cnt    = imu_acc_pkg::CNT_W'(inc);
                        n_jobs[nj] = nj0;
                        nj         = nj + 1'b1;
                    end
                end else begin
                    nj0.kind  = imu_acc_pkg::K_ACCEL;
                    nj0.x     = imu_acc_pkg::sext_word(i_item.raw_word1);
                    nj0.y     = imu_acc_pkg::sext_word(i_item.raw_word0);
                    nj0.z     = SW'(0) - imu_acc_pkg::sext_word(i_item.raw_word2);
                    n_jobs[0] = nj0;
                    nj0.kind  = imu_acc_pkg::K_GYRO;
                    nj0.x     = imu_acc_pkg::sext_word(i_item.raw_word4);
                    nj0.y     = imu_acc_pkg::sext_word(i_item.raw_word3);
                    nj0.z     = SW'(0) - imu_acc_pkg::sext_word(i_item.raw_word5);
                    n_jobs[1] = nj0;
                    nj0       = '0;
                    nj0.kind  = imu_acc_pkg::K_TEMP;
                    nj0.x     = imu_acc_pkg::sext_word(t);
                    n_jobs[2] = nj0;
                    nj        = 2'd3;
                end
            end
            if (nj != 2'd0) begin
                n_jobs[nj - 2'd1].last = 1'b1;
            end
            n_nj = nj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip  <= 1'b0;
            r_bcnt  <= '0;
            r_bsum  <= '0;
            r_cache <= '0;
            r_as    <= '{default: '0};
            r_gs    <= '{default: '0};
            r_acnt  <= '0;
            r_gcnt  <= '0;
            r_nj    <= '0;
            r_jidx  <= '0;
        end else begin
            r_skip  <= n_skip;
            r_bcnt  <= n_bcnt;
            r_bsum  <= n_bsum;
            r_cache <= n_cache;
            r_as    <= n_as;
            r_gs    <= n_gs;
            r_acnt  <= n_acnt;
            r_gcnt  <= n_gcnt;
            r_nj    <= n_nj;
            if (accept) begin
                r_jidx <= '0;
            end else if (o_push) begin
                r_jidx <= r_jidx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_jobs <= n_jobs;
    end

    `ASSERT_IMP(a_front_cnt, !r_skip && (r_nj == r_jidx), r_bcnt < BW'(MAX_BATCH))
    `ASSERT_NXT(a_front_pend, accept, r_jidx == 2'd0)
endmodule

FILE: hdl/imu_acc_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IMU accumulator job queue
// Short first-in first-out queue between the front and back ends.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module imu_acc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  imu_acc_pkg::t_job  i_job,
    output logic               o_full,
    input  logic               i_pop,
    output imu_acc_pkg::t_job  o_job,
    output logic               o_empty
);
    localparam int AW = imu_acc_pkg::Q_AW;
    localparam int D  = imu_acc_pkg::Q_DEPTH;

    imu_acc_pkg::t_job r_mem [D];
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     r_rp;
    logic [AW:0]       r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(D));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    `ASSERT_IMP(a_q_nooverflow, i_push, !o_full || i_pop)
    `ASSERT_IMP(a_q_nounderflow, i_pop, !o_empty)
endmodule

FILE: hdl/imu_acc_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IMU accumulator back end
// Scales vectors by gain, divides the batch temperature sum, drives results.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module imu_acc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  imu_acc_pkg::t_cfg  i_cfg,
    input  imu_acc_pkg::t_job  i_job,
    input  logic               i_empty,
    output logic               o_pop,
    imu_acc_out_if.source      o_res
);
    localparam int SW = imu_acc_pkg::SUM_W;
    localparam int XW = imu_acc_pkg::AXIS_W;
    localparam int CW = imu_acc_pkg::CNT_W;
    localparam int GW = imu_acc_pkg::GAIN_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                r_state;
    imu_acc_pkg::t_job     r_job;
    logic [1:0]            r_step;
    logic [4:0]            r_dstep;
    logic [SW-1:0]         r_mag;
    logic [CW-1:0]         r_rem;
    logic                  r_neg;
    logic signed [XW-1:0]  r_res [3];

    logic signed [SW-1:0]  op;
    logic [GW-1:0]         gain;
    logic signed [XW:0]    prod;
    logic [CW:0]           rem_sh;
    logic                  qbit;
    logic [SW-1:0]         mag_n;
    logic [SW-1:0]         quo;

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        case (r_step)
            2'd0:    op = r_job.x;
            2'd1:    op = r_job.y;
            default: op = r_job.z;
        endcase
    end

    assign gain   = (r_job.kind == imu_acc_pkg::K_ACCEL) ? i_cfg.accel_gain
                                                         : i_cfg.gyro_gain;
    assign prod   = op * $signed({1'b0, gain});
    assign rem_sh = {r_rem, r_mag[SW-1]};
    assign qbit   = (rem_sh >= {1'b0, r_job.cnt});
    assign mag_n  = {r_mag[SW-2:0], qbit};
    assign quo    = r_neg ? (~mag_n + 1'b1) : mag_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        case (i_job.kind)
                            imu_acc_pkg::K_ACCEL,
                            imu_acc_pkg::K_GYRO: r_state <= S_MUL;
                            imu_acc_pkg::K_TEMP: r_state <= i_job.div ? S_DIV : S_OUT;
                            default:             r_state <= S_OUT;
                        endcase
                    end
                end
                S_MUL: begin
                    if (r_step == 2'd2) begin
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (r_dstep == 5'(SW - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job   <= i_job;
                r_step  <= '0;
                r_dstep <= '0;
                r_rem   <= '0;
                r_neg   <= i_job.x[SW-1];
                r_mag   <= i_job.x[SW-1] ? (~i_job.x + 1'b1) : i_job.x;
                r_res[1] <= '0;
                r_res[2] <= '0;
                if (i_job.kind == imu_acc_pkg::K_TEMP) begin
                    r_res[0] <= XW'(i_job.x);
                end else begin
                    r_res[0] <= '0;
                end
            end
            S_MUL: begin
                r_res[r_step] <= prod[XW-1:0];
                r_step        <= r_step + 1'b1;
            end
            S_DIV: begin
                r_rem   <= qbit ? CW'(rem_sh - {1'b0, r_job.cnt}) : rem_sh[CW-1:0];
                r_mag   <= mag_n;
                r_dstep <= r_dstep + 1'b1;
                if (r_dstep == 5'(SW - 1)) begin
                    r_res[0] <= XW'($signed(quo));
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.valid  = (r_state == S_OUT);
    assign o_res.kind   = r_job.kind;
    assign o_res.axis_x = r_res[0];
    assign o_res.axis_y = r_res[1];
    assign o_res.axis_z = r_res[2];
    assign o_res.last   = r_job.last;

    `ASSERT_NXT(a_back_pop, o_pop, r_state != S_IDLE)
    `ASSERT_IMP(a_back_div, r_state == S_DIV, r_job.cnt != '0)
endmodule

FILE: hdl/imu_fifo_sample_accumulator_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IMU FIFO sample accumulator
// Temperature-checked accumulation and decimation of inertial FIFO records.
// ---------------------------------------------------------------------------
// One FIFO record enters per item on i_item; up to three results leave per
// item on o_res, the final one of each record marked by last. The user must
// write registers through i_cfg_we, i_cfg_idx and i_cfg_data only while the
// block is idle; the block itself does not enforce this. The front end takes
// a record and then hands its jobs to a four-entry queue, one per cycle
// while the queue is not full; it takes no new record until all jobs of the
// last one are in the queue. The back end has one 20 by 25 bit multiplier
// and scales the x, y and z of a vector in turn; the batch temperature
// average uses a bit-serial divider.
// Reset clears sums, counters, the temperature cache and the queue, and
// loads the register defaults. When the receiver stalls, the result holds,
// the queue fills, and then i_item.ready drops.
// ---------------------------------------------------------------------------
module imu_fifo_sample_accumulator_core #(
    parameter int MAX_BATCH = imu_acc_pkg::MAX_BATCH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    imu_acc_in_if.sink                           i_item,
    imu_acc_out_if.source                        o_res,
    input  logic                                 i_cfg_we,
    input  logic [imu_acc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [imu_acc_pkg::GAIN_W-1:0]       i_cfg_data
);
    imu_acc_pkg::t_cfg r_cfg;
    imu_acc_pkg::t_job front_job;
    imu_acc_pkg::t_job head_job;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_mode  <= 1'b0;
            r_cfg.accel_ds   <= 4'd1;
            r_cfg.gyro_ds    <= 4'd1;
            r_cfg.accel_gain <= imu_acc_pkg::ACCEL_GAIN_RST;
            r_cfg.gyro_gain  <= imu_acc_pkg::GYRO_GAIN_RST;
            r_cfg.temp_tol   <= imu_acc_pkg::TEMP_TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                imu_acc_pkg::CFG_FAST_MODE:  r_cfg.fast_mode  <= i_cfg_data[0];
                imu_acc_pkg::CFG_ACCEL_DS:   r_cfg.accel_ds   <= i_cfg_data[3:0];
                imu_acc_pkg::CFG_GYRO_DS:    r_cfg.gyro_ds    <= i_cfg_data[3:0];
                imu_acc_pkg::CFG_ACCEL_GAIN: r_cfg.accel_gain <= i_cfg_data;
                imu_acc_pkg::CFG_GYRO_GAIN:  r_cfg.gyro_gain  <= i_cfg_data;
                imu_acc_pkg::CFG_TEMP_TOL:   r_cfg.temp_tol   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    imu_acc_front #(
        .MAX_BATCH (MAX_BATCH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_job   (front_job),
        .o_push  (push),
        .i_full  (full)
    );

    imu_acc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty)
    );

    imu_acc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_job   (head_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );
endmodule
